// ===== rtl/core/hlf_pkg.sv =====
// ============================================================================
// hlf_pkg: shared types, constants and helpers of the hexdump line formatter
// Holds the controller states, the command and status words between the
// controller and the datapath, and the character helper functions.
// ============================================================================
package hlf_pkg;

    // Default number of byte columns on one dump line.
    localparam int BYTES_PER_LINE_DEF = 16;
    // Column after which the hex area gets one extra space.
    localparam int EXTRA_GAP_COL      = 7;
    // Number of hex digits in the line offset.
    localparam int ADDR_DIGITS        = 8;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_BAR     = 8'h7C;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] PRINT_LO     = 8'h20;
    localparam logic [7:0] PRINT_HI     = 8'h7E;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_GAP,
        ST_HEX_HI,
        ST_HEX_LO,
        ST_SEP,
        ST_SEP7,
        ST_PAD,
        ST_BAR_SP,
        ST_BAR_OPEN,
        ST_ASCII,
        ST_BAR_CLOSE,
        ST_NEWLINE
    } hlf_state_t;

    // Source of the character loaded into the output register.
    typedef enum logic [2:0] {
        CH_ADDR,
        CH_SPACE,
        CH_HEX_HI,
        CH_HEX_LO,
        CH_BAR,
        CH_ASCII,
        CH_NEWLINE
    } hlf_char_t;

    // Operation on the shared column/digit counter.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CLEAR,
        IDX_INC,
        IDX_LOAD_FILL,
        IDX_PAD
    } hlf_idx_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        accept;
        logic        emit;
        logic        last;
        hlf_char_t   char_sel;
        hlf_idx_op_t idx_op;
    } hlf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_ready;
        logic col_zero;
        logic x7;
        logic close;
        logic full;
        logic addr_end;
        logic gap_end;
        logic pad_end;
        logic ascii_end;
    } hlf_status_t;

    // Lowercase ASCII hex digit of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

    // Printable bytes stand as themselves, all others as a dot.
    function automatic logic [7:0] print_char(input logic [7:0] b);
        logic [7:0] c;
        if (b >= PRINT_LO && b <= PRINT_HI) begin
            c = b;
        end else begin
            c = CHAR_DOT;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/hlf_datapath.sv =====
// ============================================================================
// hlf_datapath: registers, line store and character mux of the formatter
// Captures each input byte, keeps the line column and buffer position,
// and loads one output character per command into the output register.
// ============================================================================
module hlf_datapath import hlf_pkg::*; #(
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  hlf_cmd_t    cmd,
    output hlf_status_t status,
    output logic        m_tvalid,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        m_tready
);

    localparam int IW = $clog2(BYTES_PER_LINE);
    localparam int CW = $clog2(BYTES_PER_LINE + 1);

    logic [31:0]   start_offset_reg;
    logic [IW-1:0] col_reg;
    logic [31:0]   pos_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]    sub_reg, sub_next;
    logic          m_valid_reg;
    logic [7:0]    m_data_reg;
    logic          m_last_reg;

    logic [31:0]   addr_reg;
    logic [7:0]    byte_reg;
    logic          x7_reg;
    logic          close_reg;
    logic [CW-1:0] fill_reg;
    logic [7:0]    line_store [BYTES_PER_LINE];

    logic [CW-1:0] col_inc;
    logic          close_now;
    logic          out_ready;
    logic [1:0]    sub_max;
    logic          pad_unit_end;
    logic [7:0]    char_sel_val;

    // Column after this byte and whether the line closes with it.
    assign col_inc   = CW'(col_reg) + CW'(1);
    assign close_now = (col_inc == CW'(BYTES_PER_LINE)) || s_tlast;
    assign out_ready = !m_valid_reg || m_tready;

    // Padding takes three spaces per column, four at column EXTRA_GAP_COL.
    assign sub_max      = (idx_reg == IW'(EXTRA_GAP_COL)) ? 2'd3 : 2'd2;
    assign pad_unit_end = (sub_reg == sub_max);

    // Status toward the controller.
    always_comb begin
        status.out_ready = out_ready;
        status.col_zero  = (col_reg == '0);
        status.x7        = x7_reg;
        status.close     = close_reg;
        status.full      = (fill_reg == CW'(BYTES_PER_LINE));
        status.addr_end  = (idx_reg == IW'(ADDR_DIGITS - 1));
        status.gap_end   = (idx_reg == IW'(1));
        status.pad_end   = pad_unit_end && (idx_reg == IW'(BYTES_PER_LINE - 1));
        status.ascii_end = ((CW'(idx_reg) + CW'(1)) == fill_reg);
    end

    // Counter updates for digit, pad and text positions.
    always_comb begin
        idx_next = idx_reg;
        sub_next = sub_reg;
        case (cmd.idx_op)
            IDX_CLEAR: begin
                idx_next = '0;
                sub_next = '0;
            end
            IDX_INC: begin
                idx_next = idx_reg + IW'(1);
            end
            IDX_LOAD_FILL: begin
                idx_next = fill_reg[IW-1:0];
                sub_next = '0;
            end
            IDX_PAD: begin
                if (pad_unit_end) begin
                    idx_next = idx_reg + IW'(1);
                    sub_next = '0;
                end else begin
                    sub_next = sub_reg + 2'd1;
                end
            end
            default: begin
                idx_next = idx_reg;
                sub_next = sub_reg;
            end
        endcase
    end

    // Character selection.
    always_comb begin
        case (cmd.char_sel)
            CH_ADDR:    char_sel_val = hex_char(addr_reg[31:28]);
            CH_SPACE:   char_sel_val = CHAR_SPACE;
            CH_HEX_HI:  char_sel_val = hex_char(byte_reg[7:4]);
            CH_HEX_LO:  char_sel_val = hex_char(byte_reg[3:0]);
            CH_BAR:     char_sel_val = CHAR_BAR;
            CH_ASCII:   char_sel_val = print_char(line_store[idx_reg]);
            CH_NEWLINE: char_sel_val = CHAR_NEWLINE;
            default:    char_sel_val = CHAR_SPACE;
        endcase
    end

    // Control state: offset register, line column, buffer position, counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_offset_reg <= '0;
            col_reg          <= '0;
            pos_reg          <= '0;
            idx_reg          <= '0;
            sub_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                start_offset_reg <= cfg_wr_data;
            end
            if (cmd.accept) begin
                col_reg <= close_now ? '0 : (col_reg + IW'(1));
                pos_reg <= s_tlast ? '0 : (pos_reg + 32'd1);
            end
            idx_reg <= idx_next;
            sub_reg <= sub_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: captured byte, line store, offset shifter and output word.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            line_store[col_reg] <= s_tdata;
            byte_reg            <= s_tdata;
            x7_reg              <= (col_reg == IW'(EXTRA_GAP_COL));
            close_reg           <= close_now;
            fill_reg            <= col_inc;
            addr_reg            <= start_offset_reg + pos_reg;
        end else if (cmd.emit && cmd.char_sel == CH_ADDR) begin
            addr_reg <= {addr_reg[27:0], 4'h0};
        end
        if (cmd.emit) begin
            m_data_reg <= char_sel_val;
            m_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/hlf_ctrl.sv =====
// ============================================================================
// hlf_ctrl: sequencing state machine of the hexdump formatter
// Walks through the offset, hex, padding and text parts of each item and
// issues one character command per cycle the output register can take it.
// ============================================================================
module hlf_ctrl import hlf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  hlf_status_t status,
    output hlf_cmd_t    cmd
);

    hlf_state_t state_reg, state_next;
    logic       emit;
    hlf_state_t close_target;

    assign emit = (state_reg != ST_IDLE) && status.out_ready;

    // After the hex group: close the line or finish the item.
    always_comb begin
        if (!status.close) begin
            close_target = ST_IDLE;
        end else if (status.full) begin
            close_target = ST_BAR_SP;
        end else begin
            close_target = ST_PAD;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.col_zero ? ST_ADDR : ST_HEX_HI;
                end
            end
            ST_ADDR: begin
                if (emit && status.addr_end) state_next = ST_GAP;
            end
            ST_GAP: begin
                if (emit && status.gap_end) state_next = ST_HEX_HI;
            end
            ST_HEX_HI: begin
                if (emit) state_next = ST_HEX_LO;
            end
            ST_HEX_LO: begin
                if (emit) state_next = ST_SEP;
            end
            ST_SEP: begin
                if (emit) state_next = status.x7 ? ST_SEP7 : close_target;
            end
            ST_SEP7: begin
                if (emit) state_next = close_target;
            end
            ST_PAD: begin
                if (emit && status.pad_end) state_next = ST_BAR_SP;
            end
            ST_BAR_SP: begin
                if (emit) state_next = ST_BAR_OPEN;
            end
            ST_BAR_OPEN: begin
                if (emit) state_next = ST_ASCII;
            end
            ST_ASCII: begin
                if (emit && status.ascii_end) state_next = ST_BAR_CLOSE;
            end
            ST_BAR_CLOSE: begin
                if (emit) state_next = ST_NEWLINE;
            end
            ST_NEWLINE: begin
                if (emit) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands for the current state.
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.emit     = emit;
        cmd.last     = 1'b0;
        cmd.char_sel = CH_SPACE;
        cmd.idx_op   = IDX_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.idx_op = IDX_CLEAR;
            end
            ST_ADDR: begin
                cmd.char_sel = CH_ADDR;
                if (emit) cmd.idx_op = status.addr_end ? IDX_CLEAR : IDX_INC;
            end
            ST_GAP: begin
                cmd.char_sel = CH_SPACE;
                if (emit) cmd.idx_op = IDX_INC;
            end
            ST_HEX_HI: begin
                cmd.char_sel = CH_HEX_HI;
            end
            ST_HEX_LO: begin
                cmd.char_sel = CH_HEX_LO;
            end
            ST_SEP: begin
                cmd.char_sel = CH_SPACE;
                cmd.last     = !status.x7 && !status.close;
                if (emit) cmd.idx_op = IDX_LOAD_FILL;
            end
            ST_SEP7: begin
                cmd.char_sel = CH_SPACE;
                cmd.last     = !status.close;
                if (emit) cmd.idx_op = IDX_LOAD_FILL;
            end
            ST_PAD: begin
                cmd.char_sel = CH_SPACE;
                if (emit) cmd.idx_op = IDX_PAD;
            end
            ST_BAR_SP: begin
                cmd.char_sel = CH_SPACE;
            end
            ST_BAR_OPEN: begin
                cmd.char_sel = CH_BAR;
                if (emit) cmd.idx_op = IDX_CLEAR;
            end
            ST_ASCII: begin
                cmd.char_sel = CH_ASCII;
                if (emit) cmd.idx_op = IDX_INC;
            end
            ST_BAR_CLOSE: begin
                cmd.char_sel = CH_BAR;
            end
            ST_NEWLINE: begin
                cmd.char_sel = CH_NEWLINE;
                cmd.last     = 1'b1;
            end
            default: begin
                cmd.char_sel = CH_SPACE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/hexdump_line_formatter.sv =====
// ============================================================================
// hexdump_line_formatter: canonical hexdump text generator
// Turns a stream of raw bytes into the ASCII text of a canonical hexdump.
// ============================================================================
// The slave channel takes one raw byte per word; s_tlast marks the final
// byte of a buffer. The master channel gives one ASCII character per word;
// m_tlast marks the last character produced by that input byte.
// A line starts with the offset (start_offset plus the byte position in the
// buffer) as eight hex digits, then two hex digits and a space per byte.
// A full line or the end of a buffer closes the line with padding, the
// printable text between bars and a newline; the buffer position then
// restarts at zero after the end of a buffer.
// Each input word gives 3 to 64 characters, about 5 per byte over a full
// line of 16 bytes. The single character output register sets a pace of one
// character per cycle while the receiver is ready. The first character goes
// through the state register and then the output register after acceptance;
// the next word is taken while the final character still waits in the output
// register. When the receiver stalls, the sequencer holds and no character
// is lost. Reset clears the column, position and offset register to zero.
// The user must write start_offset through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
// ============================================================================
module hexdump_line_formatter import hlf_pkg::*; #(
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // start_offset register write
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // Raw byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_buffer
    // Character output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast    // last_char
);

    hlf_cmd_t    cmd;
    hlf_status_t status;

    // Sequencer.
    hlf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, line store and output stage.
    hlf_datapath #(
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tready    (m_tready)
    );

    // An accepted word keeps the input closed for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // The final character of a word reopens the input and sits in the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && cmd.last |=> s_tready && m_tvalid && m_tlast)
        else $error("final character not followed by idle input and tlast");

    // A newline always ends the characters of its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && (cmd.char_sel == CH_NEWLINE) |-> cmd.last)
        else $error("newline emitted without last flag");

endmodule

// ===== sim/hlf_text_checker.sv =====
// ============================================================================
// hlf_text_checker: dump text predictor and scoreboard
// Watches the byte, character and offset-register traffic of the hexdump
// line formatter, predicts the dump text for every accepted byte word and
// compares each accepted character word against the oldest prediction.
// ============================================================================
module hlf_text_checker import hlf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_buffer
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_char
    input  logic        m_tlast,   // last_char
    output int unsigned fail_count,
    output int unsigned chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_BYTES = BYTES_PER_LINE_DEF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } dump_char_t;

    // Predicted text, oldest character first.
    dump_char_t  text_q[$];

    // Own copy of the formatter state.
    logic [7:0]  line_bytes [LINE_BYTES];
    int unsigned line_col;
    logic [31:0] buf_pos;
    logic [31:0] base_offset;
    int unsigned fails;

    initial begin
        fails         = 0;
        line_col      = 0;
        buf_pos       = '0;
        base_offset   = '0;
    end

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib > 4'd9) begin
            c = 8'h61 + 8'(nib - 4'd10);
        end else begin
            c = 8'h30 + 8'(nib);
        end
        return c;
    endfunction

    task automatic push_char(input logic [7:0] c);
        dump_char_t e;
        e.ch   = c;
        e.last = 1'b0;
        text_q.insert(text_q.size(), e);
    endtask

    // Append the text that one byte word causes and advance the line state.
    task automatic format_byte(input logic [7:0] b, input logic eob);
        logic [31:0] addr;
        logic [7:0]  sb;
        // A new line opens with its offset and two spaces.
        if (line_col == 0) begin
            addr = base_offset + buf_pos;
            for (int s = 7; s >= 0; s--) begin
                push_char(nibble_char(addr[s*4 +: 4]));
            end
            push_char(CHAR_SPACE);
            push_char(CHAR_SPACE);
        end
        push_char(nibble_char(b[7:4]));
        push_char(nibble_char(b[3:0]));
        push_char(CHAR_SPACE);
        if (line_col == EXTRA_GAP_COL) begin
            push_char(CHAR_SPACE);
        end
        line_bytes[line_col] = b;
        line_col++;
        buf_pos++;
        // A full line or the end of the buffer closes the line.
        if (line_col == LINE_BYTES || eob) begin
            for (int c = line_col; c < LINE_BYTES; c++) begin
                push_char(CHAR_SPACE);
                push_char(CHAR_SPACE);
                push_char(CHAR_SPACE);
                if (c == EXTRA_GAP_COL) begin
                    push_char(CHAR_SPACE);
                end
            end
            push_char(CHAR_SPACE);
            push_char(CHAR_BAR);
            for (int i = 0; i < line_col; i++) begin
                sb = line_bytes[i];
                push_char((sb >= PRINT_LO && sb <= PRINT_HI) ? sb : CHAR_DOT);
            end
            push_char(CHAR_BAR);
            push_char(CHAR_NEWLINE);
            line_col = 0;
            if (eob) begin
                buf_pos = '0;
            end
        end
        text_q[text_q.size() - 1].last = 1'b1;
    endtask

    // Sample all channels at the clock edge, predict, then compare.
    always @(posedge aclk) begin
        dump_char_t want;
        logic       bad;
        if (!aresetn) begin
            line_col    = 0;
            buf_pos     = '0;
            base_offset = '0;
            text_q.delete();
        end else begin
            if (cfg_wr_en) begin
                base_offset = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                format_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (text_q.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual char %h last %b",
                             $time, m_tdata, m_tlast);
                    fails++;
                end else begin
                    want = text_q.pop_front();
                    bad  = 1'b0;
                    if (m_tdata !== want.ch) begin
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.ch, m_tdata);
                        bad = 1'b1;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        fails++;
                    end
                end
            end
        end
        fail_count    <= fails;
        chars_pending <= text_q.size();
    end

endmodule

// ===== sim/tb.sv =====
// ============================================================================
// tb: hexdump line formatter testbench
// Drives byte buffers with random gaps and receiver stalls across several
// start offsets, including offset wrap, and reports the checker's verdict.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_WORDS = 75;
    localparam int unsigned PAUSE_AT    = 200;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;    // [7:0] data_byte
    logic        s_tlast     = 1'b0;  // end_of_buffer
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;             // [7:0] out_char
    logic        m_tlast;             // last_char

    int unsigned fail_count;
    int unsigned chars_pending;
    int unsigned cycles      = 0;
    int unsigned words_sent  = 0;
    int unsigned rx_hold     = 0;
    bit          no_idle     = 1'b0;

    logic [7:0] dir_bytes [17] = '{
        8'h00, 8'hff, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h41, 8'h80,
        8'h0a, 8'h55, 8'haa, 8'h7c, 8'h2e, 8'h30, 8'h39, 8'h61, 8'h5a
    };

    hexdump_line_formatter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    hlf_text_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 20);
    endfunction

    // Receiver: ready bursts alternate with stalls.
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
        end else if (no_idle || !m_tready) begin
            m_tready <= 1'b1;
            rx_hold = $urandom_range(0, 12);
        end else begin
            rx_hold = pick_gap();
            if (rx_hold != 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stop sending and wait until the whole predicted text has come out.
    task automatic drain_text();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_offset(input logic [31:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Offer one byte word, wait for the handshake, then maybe leave a gap.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int unsigned gap;
        if (words_sent == PAUSE_AT) begin
            drain_text();
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_buffer(input int unsigned len);
        bit         text_like;
        logic [7:0] b;
        text_like = $urandom_range(0, 1);
        for (int unsigned i = 0; i < len; i++) begin
            b = text_like ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 1;
        if (r < 20) return 16;
        if (r < 27) return 15;
        if (r < 34) return 32;
        if (r < 38) return 8;
        if (r < 43) return $urandom_range(50, 90);
        return $urandom_range(2, 40);
    endfunction

    initial begin : stimulus
        int unsigned sent;
        logic [31:0] offset;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // One full line near the top of the address space, then a lone
        // closing byte whose offset has wrapped past zero.
        write_offset(32'hffff_fff8);
        for (int i = 0; i < 17; i++) begin
            send_byte(dir_bytes[i], i == 16);
        end
        // A buffer that ends on the column with the extra gap.
        for (int i = 0; i < 8; i++) begin
            send_byte(dir_bytes[i + 1], i == 7);
        end

        // Random buffers under several offsets.
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            drain_text();
            case (ph)
                0: begin
                    offset = 32'hffff_ffff;
                end
                1: begin
                    offset = 32'h0000_0000;
                end
                2: begin
                    offset = 32'hffff_ffc0 + 32'($urandom_range(0, 63));
                end
                4: begin
                    offset = 32'h7fff_fff0;
                end
                default: begin
                    offset = $urandom;
                end
            endcase
            write_offset(offset);
            no_idle = (ph == 3);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                offset = pick_length();
                // The last buffer of a phase is cut to the words still due.
                if (offset > PHASE_WORDS - sent) begin
                    offset = PHASE_WORDS - sent;
                end
                send_buffer(offset);
                sent += offset;
            end
        end
        no_idle = 1'b0;

        drain_text();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
